// File: hdl/ialu_pkg.sv
// ----------------------------------------------------------------------------
// ialu_pkg: shared types and constants of the 64-bit integer ALU
// Action codes, word width, pipeline depth and the stage record.
// ----------------------------------------------------------------------------
package ialu_pkg;
  localparam int unsigned WordW  = 64;
  localparam int unsigned ActW   = 4;
  localparam int unsigned BitsPerCell = 2;
  localparam int unsigned DivCells = WordW / BitsPerCell;

  localparam logic [ActW-1:0] ACT_NOT = 4'd0;
  localparam logic [ActW-1:0] ACT_AND = 4'd1;
  localparam logic [ActW-1:0] ACT_OR  = 4'd2;
  localparam logic [ActW-1:0] ACT_XOR = 4'd3;
  localparam logic [ActW-1:0] ACT_SHL = 4'd4;
  localparam logic [ActW-1:0] ACT_SRA = 4'd5;
  localparam logic [ActW-1:0] ACT_SRL = 4'd6;
  localparam logic [ActW-1:0] ACT_ROR = 4'd7;
  localparam logic [ActW-1:0] ACT_ROL = 4'd8;
  localparam logic [ActW-1:0] ACT_INC = 4'd9;
  localparam logic [ActW-1:0] ACT_DEC = 4'd10;
  localparam logic [ActW-1:0] ACT_ADD = 4'd11;
  localparam logic [ActW-1:0] ACT_SUB = 4'd12;
  localparam logic [ActW-1:0] ACT_MUL = 4'd13;
  localparam logic [ActW-1:0] ACT_DIV = 4'd14;
  localparam logic [ActW-1:0] ACT_MOD = 4'd15;

  // One word in flight through the cell chain
  typedef struct packed {
    logic             vld;
    logic [ActW-1:0]  act;
    logic [WordW-1:0] res;    // finished result or quotient bits
    logic [WordW-1:0] rem;    // partial remainder
    logic [WordW-1:0] num;    // dividend magnitude, shifted out msb first
    logic [WordW-1:0] den;    // divisor magnitude
    logic             neg_q;
    logic             neg_r;
    logic             dz;
  } stage_t;
endpackage

// File: hdl/ialu_if.sv
// ----------------------------------------------------------------------------
// ialu_in_if / ialu_out_if: valid/ready channels of the ALU
// Input words carry action and operands, output words the result.
// ----------------------------------------------------------------------------
interface ialu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface ialu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        divide_by_zero;
  modport source (output valid, result, divide_by_zero, input ready);
  modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

// File: hdl/integer_alu_64_top.sv
// Every action passes through the front stage, the chain of divide cells and the output register.
// Throughput: one word per cycle; the divide chain of cells retires
// two quotient bits per cell and the multiplier result rides alongside.
// The whole pipeline stalls only when the output word is not taken.
// Reset (rst_n low, synchronous) clears all valid bits; data is not cleared.
// ----------------------------------------------------------------------------
// integer_alu_64_top: pipelined 64-bit integer ALU
// Front stage, chain of divide cells, multiply delay line, final fix-up.
// ----------------------------------------------------------------------------
module integer_alu_64_top (
  input  logic       clk,
  input  logic       rst_n,
  ialu_in_if.sink    in_ch,
  ialu_out_if.source out_ch
);
  import ialu_pkg::*;

  localparam int unsigned NCells = DivCells;

  stage_t           chain [NCells+1];
  logic [WordW-1:0] ll_r, lh_r, hl_r, mul_r;
  logic [WordW-1:0] mul_d [NCells];
  logic             en;
  logic             out_vld_r;
  logic [WordW-1:0] out_res_r;
  logic             out_dz_r;
  stage_t           last;
  logic [WordW-1:0] fin;

  // Stall everything while a result waits unaccepted
  assign en           = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = en;

  ialu_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_ch.valid), .in_act(in_ch.action),
    .in_a(in_ch.operand_a), .in_b(in_ch.operand_b),
    .st_r(chain[0]), .mul_ll_r(ll_r), .mul_lh_r(lh_r), .mul_hl_r(hl_r)
  );

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    ialu_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .st_in(chain[g]), .st_r(chain[g+1])
    );
  end

  // Sum the partial products, then delay alongside the chain
  always_ff @(posedge clk) begin
    if (en) begin
      mul_d[0] <= ll_r + {lh_r[31:0] + hl_r[31:0], 32'd0};
      for (int i = 1; i < NCells; i++) mul_d[i] <= mul_d[i-1];
    end
  end
  assign mul_r = mul_d[NCells-1];
  assign last  = chain[NCells];

  // Pick the final value
  always_comb begin
    case (last.act)
      ACT_MUL: fin = mul_r;
      ACT_DIV: fin = last.dz ? '0 : (last.neg_q ? (64'd0 - last.res) : last.res);
      ACT_MOD: fin = last.dz ? '0 : (last.neg_r ? (64'd0 - last.rem) : last.rem);
      default: fin = last.res;
    endcase
  end

  // Hold the output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= fin;
      out_dz_r  <= last.dz;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.result         = out_res_r;
  assign out_ch.divide_by_zero = out_dz_r;
endmodule

// File: hdl/ialu_front.sv
// ----------------------------------------------------------------------------
// ialu_front: first stage of the ALU
// Works out the logic, shift, rotate, add and subtract actions, starts the multiplier partials and
// prepares divide magnitudes for the cell chain.
// ----------------------------------------------------------------------------
module ialu_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [3:0]            in_act,
  input  logic [63:0]           in_a,
  input  logic [63:0]           in_b,
  output ialu_pkg::stage_t      st_r,
  output logic [63:0]           mul_ll_r,
  output logic [63:0]           mul_lh_r,
  output logic [63:0]           mul_hl_r
);
  import ialu_pkg::*;

  stage_t           st_nxt;
  logic [WordW-1:0] mag_a, mag_b, sh_res, rot_r, rot_l;
  logic [5:0]       k;
  logic             big;

  // Shift and rotate helpers, and the operand magnitudes
  always_comb begin
    k   = in_a[5:0];
    big = |in_a[63:6];
    rot_r = (in_b >> k) | (in_b << (7'd64 - {1'b0, k}));
    rot_l = (in_b << k) | (in_b >> (7'd64 - {1'b0, k}));
    if (k == 6'd0) begin
      rot_r = in_b;
      rot_l = in_b;
    end
    case (in_act)
      ACT_SHL: sh_res = big ? '0 : (in_b << k);
      ACT_SRL: sh_res = big ? '0 : (in_b >> k);
      ACT_SRA: sh_res = big ? {WordW{in_b[63]}} : WordW'($signed(in_b) >>> k);
      ACT_ROR: sh_res = rot_r;
      default: sh_res = rot_l;
    endcase
    mag_a = in_a[63] ? (64'd0 - in_a) : in_a;
    mag_b = in_b[63] ? (64'd0 - in_b) : in_b;
  end

  // Build the word entering the chain
  always_comb begin
    st_nxt       = '0;
    st_nxt.vld   = in_vld;
    st_nxt.act   = in_act;
    st_nxt.num   = mag_b;
    st_nxt.den   = mag_a;
    st_nxt.neg_q = in_a[63] ^ in_b[63];
    st_nxt.neg_r = in_b[63];
    case (in_act)
      ACT_NOT: st_nxt.res = ~in_a;
      ACT_AND: st_nxt.res = in_b & in_a;
      ACT_OR:  st_nxt.res = in_b | in_a;
      ACT_XOR: st_nxt.res = in_b ^ in_a;
      ACT_SHL, ACT_SRA, ACT_SRL, ACT_ROR, ACT_ROL: st_nxt.res = sh_res;
      ACT_INC: st_nxt.res = in_a + 64'd1;
      ACT_DEC: st_nxt.res = in_a - 64'd1;
      ACT_ADD: st_nxt.res = in_b + in_a;
      ACT_SUB: st_nxt.res = in_b - in_a;
      ACT_DIV, ACT_MOD: st_nxt.dz = (in_a == '0);
      default: st_nxt.res = '0;
    endcase
  end

  // Advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r.vld <= st_nxt.vld;
    end
    if (en) begin
      st_r.act   <= st_nxt.act;
      st_r.res   <= st_nxt.res;
      st_r.rem   <= st_nxt.rem;
      st_r.num   <= st_nxt.num;
      st_r.den   <= st_nxt.den;
      st_r.neg_q <= st_nxt.neg_q;
      st_r.neg_r <= st_nxt.neg_r;
      st_r.dz    <= st_nxt.dz;
      mul_ll_r   <= in_b[31:0] * in_a[31:0];
      mul_lh_r   <= in_b[31:0] * in_a[63:32];
      mul_hl_r   <= in_b[63:32] * in_a[31:0];
    end
  end
endmodule

// File: hdl/ialu_cell.sv
// ----------------------------------------------------------------------------
// ialu_cell: one link of the divide chain
// Retires BitsPerCell quotient bits of a divide word, passes others through.
// ----------------------------------------------------------------------------
module ialu_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  ialu_pkg::stage_t st_in,
  output ialu_pkg::stage_t st_r
);
  import ialu_pkg::*;

  stage_t          st_nxt;
  logic [WordW:0]  trial;
  logic [WordW-1:0] r, q, n;
  logic            is_div;

  // Restoring steps, one bit each
  always_comb begin
    is_div = (st_in.act == ACT_DIV) || (st_in.act == ACT_MOD);
    r = st_in.rem;
    q = st_in.res;
    n = st_in.num;
    trial = '0;
    for (int i = 0; i < BitsPerCell; i++) begin
      trial = {r, n[WordW-1]} - {1'b0, st_in.den};
      if (!trial[WordW]) begin
        r = trial[WordW-1:0];
        q = {q[WordW-2:0], 1'b1};
      end else begin
        r = {r[WordW-2:0], n[WordW-1]};
        q = {q[WordW-2:0], 1'b0};
      end
      n = {n[WordW-2:0], 1'b0};
    end
    st_nxt = st_in;
    if (is_div) begin
      st_nxt.rem = r;
      st_nxt.res = q;
      st_nxt.num = n;
    end
  end

  // Hand the word to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r.vld <= st_nxt.vld;
    end
    if (en) begin
      st_r.act   <= st_nxt.act;
      st_r.res   <= st_nxt.res;
      st_r.rem   <= st_nxt.rem;
      st_r.num   <= st_nxt.num;
      st_r.den   <= st_nxt.den;
      st_r.neg_q <= st_nxt.neg_q;
      st_r.neg_r <= st_nxt.neg_r;
      st_r.dz    <= st_nxt.dz;
    end
  end
endmodule

// File: hdl/ialu_checker.sv
// ----------------------------------------------------------------------------
// ialu_checker: port-level checks of the ALU
// Watches the handshakes and the divide flag over time.
// ----------------------------------------------------------------------------
module ialu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result,
  input logic        out_dz
);
  // A stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("output word changed while stalled");

  // Input is taken whenever no output waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Zero flag forces a zero result
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dz |-> out_result == 64'd0)
    else $error("divide by zero with nonzero result");

  // Nothing valid just after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind integer_alu_64_top ialu_checker u_ialu_checker (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result(out_ch.result), .out_dz(out_ch.divide_by_zero)
);
